/* src/spr_pkg.sv */
// Package for the streaming find-and-replace block.
// Shared widths, configuration register indexes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  // Default for the longest search / replacement pattern, in bytes (1..8)
  localparam int unsigned MAX_PATTERN_BYTES_DEF = 8;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAT_W      = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned TALLY_W    = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_PATTERN      = 2'd0,
    CFG_SEARCH_LENGTH       = 2'd1,
    CFG_REPLACEMENT_PATTERN = 2'd2,
    CFG_REPLACEMENT_LENGTH  = 2'd3
  } spr_cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,    // ready for the next text byte
    ST_DECIDE,  // compare held bytes against the search pattern
    ST_REPL,    // send the replacement, one byte per beat
    ST_REL      // release held bytes that can no longer match
  } spr_state_e;

endpackage : spr_pkg

`default_nettype wire

/* src/stream_pattern_replace.sv */
// Streaming find-and-replace: top level and only module.
// Depends on spr_pkg (widths, register indexes, sequencer states).
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one text byte per beat
//   (text_byte_i, text_last_i). Output channel: out_valid_o / out_stall_i
//   carry one rewritten byte per beat (out_byte_o, out_last_o, and
//   match_total_o, which is nonzero only on the out_last_o beat).
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i)
//   and is to be written only while the block is idle; the block itself
//   does not enforce this. Each accepted byte is latched, compared with
//   the search pattern in ST_DECIDE, then sent as result beats from ST_REPL
//   or ST_REL through the output register, one result beat per cycle while
//   the receiver does not stall, up to 8 result beats. ST_REL checks each
//   release with the shared compare unit and ends with a closing step.
//   in_stall_o is high whenever the sequencer is busy with a byte.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits; no beat is dropped.
//   Reset clears held bytes, the replacement count and the sequencer, and
//   sets both patterns to 0 and both lengths to 1.
`timescale 1ns / 1ps
`default_nettype none

module stream_pattern_replace
  import spr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input text beats
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     text_byte_i,
  input  wire logic                  text_last_i,
  // output text beats
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [BYTE_W-1:0]          out_byte_o,
  output logic                       out_last_o,
  output logic [TALLY_W-1:0]         match_total_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // configuration registers
  logic [PAT_W-1:0] spat_q;
  logic [LEN_W-1:0] slen_raw_q;
  logic [PAT_W-1:0] rpat_q;
  logic [LEN_W-1:0] rlen_raw_q;

  // sequencer and held-byte state
  spr_state_e        state_q, state_d;
  logic [BYTE_W-1:0] pend_q [MAX_PATTERN_BYTES];
  logic [BYTE_W-1:0] pend_d [MAX_PATTERN_BYTES];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_q, last_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [TALLY_W-1:0] out_total_q, out_total_d;

  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] slen_c, rlen_c;
  logic             lanes_eq;
  logic             prefix_ok;
  logic             match_hit;
  logic             rel_need;
  logic             repl_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // length clamp: 0 counts as 1, above the maximum counts as the maximum
  always_comb begin
    if (slen_raw_q == '0) begin
      slen_c = CNT_W'(1);
    end else if (slen_raw_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      slen_c = CNT_W'(MAX_PATTERN_BYTES);
    end else begin
      slen_c = slen_raw_q[CNT_W-1:0];
    end
    if (rlen_raw_q == '0) begin
      rlen_c = CNT_W'(1);
    end else if (rlen_raw_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      rlen_c = CNT_W'(MAX_PATTERN_BYTES);
    end else begin
      rlen_c = rlen_raw_q[CNT_W-1:0];
    end
  end

  // shared compare unit: held bytes against the leading search lanes
  always_comb begin
    lanes_eq = 1'b1;
    for (int unsigned i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if ((CNT_W'(i) < cnt_q) && (pend_q[i] != spat_q[BYTE_W*i +: BYTE_W])) begin
        lanes_eq = 1'b0;
      end
    end
  end

  assign prefix_ok = (cnt_q <= slen_c) && lanes_eq;
  assign match_hit = (cnt_q == slen_c) && prefix_ok;
  assign rel_need  = (cnt_q != '0) && (last_q || (cnt_q >= slen_c) || !prefix_ok);
  assign repl_done = ((CNT_W'(ridx_q) + CNT_W'(1)) == rlen_c);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = match_hit ? ST_REPL : ST_REL;
      end
      ST_REPL: begin
        if (out_free && repl_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_REL: begin
        if (!rel_need) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output beats
  always_comb begin
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    tally_d     = tally_q;
    ridx_d      = ridx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_total_d = out_total_q;

    case (state_q)
      ST_IDLE: begin
        // append the new byte behind the held ones
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_PATTERN_BYTES)) begin
            pend_d[cnt_q[IDX_W-1:0]] = text_byte_i;
            cnt_d = cnt_q + CNT_W'(1);
          end
          last_d = text_last_i;
        end
      end
      ST_DECIDE: begin
        if (match_hit) begin
          cnt_d  = '0;
          ridx_d = '0;
          if (tally_q != '1) begin
            tally_d = tally_q + TALLY_W'(1);
          end
        end
      end
      ST_REPL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rpat_q[BYTE_W*ridx_q +: BYTE_W];
          out_last_d  = last_q && repl_done;
          out_total_d = (last_q && repl_done) ? tally_q : '0;
          ridx_d      = ridx_q + IDX_W'(1);
          if (last_q && repl_done) begin
            tally_d = '0;
          end
        end
      end
      ST_REL: begin
        // release the oldest held byte and shift the rest down
        if (rel_need && out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = pend_q[0];
          out_last_d  = last_q && (cnt_q == CNT_W'(1));
          out_total_d = (last_q && (cnt_q == CNT_W'(1))) ? tally_q : '0;
          for (int unsigned i = 0; i + 1 < MAX_PATTERN_BYTES; i++) begin
            pend_d[i] = pend_q[i + 1];
          end
          cnt_d = cnt_q - CNT_W'(1);
          if (last_q && (cnt_q == CNT_W'(1))) begin
            tally_d = '0;
          end
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      tally_q     <= '0;
      ridx_q      <= '0;
      out_valid_q <= 1'b0;
      spat_q      <= '0;
      slen_raw_q  <= LEN_W'(1);
      rpat_q      <= '0;
      rlen_raw_q  <= LEN_W'(1);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      tally_q     <= tally_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (spr_cfg_idx_e'(cfg_index_i))
          CFG_SEARCH_PATTERN:      spat_q     <= cfg_data_i[PAT_W-1:0];
          CFG_SEARCH_LENGTH:       slen_raw_q <= cfg_data_i[LEN_W-1:0];
          CFG_REPLACEMENT_PATTERN: rpat_q     <= cfg_data_i[PAT_W-1:0];
          CFG_REPLACEMENT_LENGTH:  rlen_raw_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_total_q <= out_total_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_last_o    = out_last_q;
  assign match_total_o = out_total_q;

endmodule : stream_pattern_replace

`default_nettype wire

/* test/spr_rewrite_checker.sv */
// Scoreboard for stream_pattern_replace: mirrors configuration writes, predicts
// the rewritten beats of every accepted text byte and checks them in order.
// Depends on spr_pkg for widths and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module spr_rewrite_checker
  import spr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [BYTE_W-1:0]     text_byte_i,
  input  wire logic                  text_last_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [BYTE_W-1:0]     out_byte_i,
  input  wire logic                  out_last_i,
  input  wire logic [TALLY_W-1:0]    match_total_i,
  output int                         fail_count_o,
  output int                         waiting_o,
  output int                         beats_o,
  output int                         replaced_o
);

  localparam int HELD_MAX = MAX_PATTERN_BYTES_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [TALLY_W-1:0] total;
  } text_beat_t;

  // mirrored configuration
  logic [PAT_W-1:0]   search_pat;
  logic [LEN_W-1:0]   search_len;
  logic [PAT_W-1:0]   repl_pat;
  logic [LEN_W-1:0]   repl_len;

  // predictor state: bytes held as a possible match, tally of this text
  logic [BYTE_W-1:0]  held [HELD_MAX];
  int                 held_n;
  logic [TALLY_W-1:0] tally;

  // rewritten beats still owed by the block, oldest first
  text_beat_t         rewritten_q [$];
  text_beat_t         next_beat;

  // out-of-range lengths fold into 1..HELD_MAX
  function automatic int eff_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > HELD_MAX) return HELD_MAX;
    return int'(v);
  endfunction

  function automatic bit held_is_search_prefix(int slen);
    int i;
    if (held_n > slen) return 1'b0;
    for (i = 0; i < held_n; i++) begin
      if (held[i] !== search_pat[i*BYTE_W +: BYTE_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] release_oldest();
    logic [BYTE_W-1:0] b;
    int                i;
    b = held[0];
    for (i = 1; i < held_n; i++) held[i-1] = held[i];
    held_n--;
    return b;
  endfunction

  // work out the beats that one text byte releases
  task automatic rewrite_byte(logic [BYTE_W-1:0] b, logic last);
    text_beat_t step_q [$];
    int         slen;
    int         rlen;
    int         i;
    slen = eff_len(search_len);
    rlen = eff_len(repl_len);
    if (held_n < HELD_MAX) begin
      held[held_n] = b;
      held_n++;
    end
    if (held_n == slen && held_is_search_prefix(slen)) begin
      for (i = 0; i < rlen; i++) step_q.push_back('{repl_pat[i*BYTE_W +: BYTE_W], 1'b0, '0});
      held_n = 0;
      if (tally != '1) tally++;
      replaced_o++;
    end else begin
      while (held_n > 0 && (held_n >= slen || !held_is_search_prefix(slen)))
        step_q.push_back('{release_oldest(), 1'b0, '0});
    end
    // end of text: flush, tag the final beat with the count
    if (last) begin
      while (held_n > 0) step_q.push_back('{release_oldest(), 1'b0, '0});
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].last  = 1'b1;
        step_q[step_q.size()-1].total = tally;
      end
      held_n = 0;
      tally  = '0;
    end
    foreach (step_q[j]) rewritten_q.push_back(step_q[j]);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at output beat %0d, %s: got 0x%0h, expected 0x%0h",
             beats_o, what, got, want);
    fail_count_o++;
  endtask

  // watch config port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_pat   = '0;
      search_len   = 1;
      repl_pat     = '0;
      repl_len     = 1;
      held_n       = 0;
      tally        = '0;
      rewritten_q.delete();
      fail_count_o = 0;
      waiting_o    = 0;
      beats_o      = 0;
      replaced_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (spr_cfg_idx_e'(cfg_index_i))
          CFG_SEARCH_PATTERN:      search_pat = cfg_data_i;
          CFG_SEARCH_LENGTH:       search_len = cfg_data_i[LEN_W-1:0];
          CFG_REPLACEMENT_PATTERN: repl_pat   = cfg_data_i;
          CFG_REPLACEMENT_LENGTH:  repl_len   = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rewrite_byte(text_byte_i, text_last_i);
      if (out_valid_i && !out_stall_i) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch("beat with nothing owed, byte", out_byte_i, 0);
        end else begin
          next_beat = rewritten_q.pop_front();
          if (out_byte_i !== next_beat.data)
            report_mismatch("byte", out_byte_i, next_beat.data);
          if (out_last_i !== next_beat.last)
            report_mismatch("last mark", out_last_i, next_beat.last);
          if (match_total_i !== next_beat.total)
            report_mismatch("replacement count", match_total_i, next_beat.total);
        end
        beats_o++;
      end
      waiting_o = rewritten_q.size();
    end
  end

endmodule : spr_rewrite_checker

`default_nettype wire

/* test/tb_stream_pattern_replace.sv */
// Testbench top for stream_pattern_replace: drives texts and pattern settings,
// idles both channels, and gives the verdict. Depends on spr_pkg, the block
// and spr_rewrite_checker, which predicts and compares the output beats.
`timescale 1ns / 1ps
`default_nettype none

module tb_stream_pattern_replace;
  import spr_pkg::*;

  // longest beat-free stretch: a long receiver hold-off (HOLD_CYCLES) plus slack
  localparam int QUIET_LIMIT  = 5000;
  // settling time after the last owed beat, for the block to go idle
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  // text bytes per idling mix
  localparam int PHASE_ITEMS  = 55;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  spr_cfg_idx_e          cfg_index   = CFG_SEARCH_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     text_byte   = '0;
  logic                  text_last   = 1'b0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;
  logic [TALLY_W-1:0]    match_total;

  int fails;
  int waiting;
  int beats;
  int replaced;

  // stimulus bookkeeping
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_reqs     = 0;
  int               items_sent    = 0;
  int               texts_sent    = 0;
  int               settings      = 0;
  int               quiet_cycles  = 0;
  logic [PAT_W-1:0] cur_spat      = '0;
  int               cur_slen      = 1;
  logic [BYTE_W-1:0] alpha_base   = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stream_pattern_replace dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .text_byte_i  (text_byte),
    .text_last_i  (text_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .out_last_o   (out_last),
    .match_total_o(match_total)
  );

  spr_rewrite_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .text_byte_i  (text_byte),
    .text_last_i  (text_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .out_last_i   (out_last),
    .match_total_i(match_total),
    .fail_count_o (fails),
    .waiting_o    (waiting),
    .beats_o      (beats),
    .replaced_o   (replaced)
  );

  // receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles where no beat moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d beats still owed",
               quiet_cycles, waiting);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one text byte; called and returns at a falling edge
  task automatic send_beat(logic [BYTE_W-1:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    text_byte = b;
    text_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (last) texts_sent++;
  endtask

  // let every owed beat come back, then give the block time to go idle
  task automatic settle();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(spr_cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_patterns(logic [PAT_W-1:0] spat, logic [CFG_DATA_W-1:0] slen_word,
                               logic [PAT_W-1:0] rpat, logic [CFG_DATA_W-1:0] rlen_word);
    settle();
    write_reg(CFG_SEARCH_PATTERN, spat);
    write_reg(CFG_SEARCH_LENGTH, slen_word);
    write_reg(CFG_REPLACEMENT_PATTERN, rpat);
    write_reg(CFG_REPLACEMENT_LENGTH, rlen_word);
    cur_spat = spat;
    cur_slen = (slen_word[3:0] == 0) ? 1 : ((slen_word[3:0] > 8) ? 8 : int'(slen_word[3:0]));
    settings++;
  endtask

  // lengths lean on the ends of the range, including the folded ones
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0:       return 4'd1;
      1:       return 4'd8;
      2:       return 4'd0;
      3:       return 4'd15;
      4:       return LEN_W'($urandom_range(9, 14));
      default: return LEN_W'($urandom_range(2, 7));
    endcase
  endfunction

  task automatic random_config();
    logic [PAT_W-1:0]      spat;
    logic [CFG_DATA_W-1:0] slen_word;
    logic [CFG_DATA_W-1:0] rlen_word;
    int                    i;
    alpha_base = BYTE_W'($urandom);
    spat       = {$urandom, $urandom};
    // mostly a small alphabet so repeats and overlapping prefixes show up
    if ($urandom_range(3) != 0) begin
      for (i = 0; i < 8; i++) spat[i*8 +: 8] = alpha_base + 8'($urandom_range(2));
    end
    slen_word      = {$urandom, $urandom};
    slen_word[3:0] = pick_length();
    rlen_word      = {$urandom, $urandom};
    rlen_word[3:0] = pick_length();
    load_patterns(spat, slen_word, {$urandom, $urandom}, rlen_word);
  endtask

  // text built from whole matches, prefixes and noise; optional pause
  // before byte pause_at until every owed beat has come back
  task automatic send_random_text(int pieces, int pause_at);
    logic [BYTE_W-1:0] bytes_q [$];
    int                p;
    int                i;
    int                n;
    int                k;
    if (pieces == 0) pieces = $urandom_range(1, 6);
    for (p = 0; p < pieces; p++) begin
      k = $urandom_range(99);
      if (k < 60) begin
        n = (k < 45) ? cur_slen : $urandom_range(1, cur_slen);
        for (i = 0; i < n; i++) bytes_q.push_back(cur_spat[i*8 +: 8]);
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          bytes_q.push_back($urandom_range(1) ? alpha_base + 8'($urandom_range(2))
                                              : 8'($urandom));
      end
    end
    for (i = 0; i < bytes_q.size(); i++) begin
      if (i == pause_at) begin
        in_valid = 1'b0;
        while (waiting != 0) @(negedge clk);
      end
      send_beat(bytes_q[i], i == bytes_q.size() - 1);
    end
  endtask

  initial begin : stimulus
    int mode;
    int phase_end;
    int n;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 58;

    // reset patterns: single zero byte replaced by zero
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);

    // three-byte search, folded replacement length, flush at the end
    load_patterns(64'h0000_0000_0043_4241, 64'd3, 64'hFF00_FF00_FF00_FF00, 64'd15);
    send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b0);
    send_beat(8'h43, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b0);
    send_beat(8'h43, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b1);

    // pattern changed while bytes are held mid-text; zero length folds to 1
    send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b0);
    settle();
    write_reg(CFG_SEARCH_LENGTH, 64'd0);
    cur_slen = 1;
    send_beat(8'h42, 1'b1);

    // full-width search matched on the last byte, then a text with no match
    load_patterns(64'h01FE_0100_807F_807F, 64'd8, 64'h0123_4567_89AB_CDEF, 64'd8);
    for (n = 0; n < 8; n++) send_beat(cur_spat[n*8 +: 8], n == 7);
    send_beat(8'hFF, 1'b1);

    // random texts under three idling mixes
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        random_config();
        n = items_sent + 20;
        if (mode == 0 && items_sent < phase_end - 50) begin
          // long receiver hold-off while a long text keeps coming
          hold_reqs++;
          send_random_text(12, -1);
        end
        if (mode == 1) send_random_text(6, 3);
        while (items_sent < n) send_random_text(0, -1);
      end
    end

    // single-byte search, zero replacement length folds to 1, back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_patterns(64'h0000_0000_0000_005A, 64'd1, 64'h0000_0000_0000_00A5, 64'd0);
    for (n = 0; n < 6; n++) send_beat(8'h5A, n == 5);
    send_beat(8'h5A, 1'b1);

    settle();
    $display("covered %0d text bytes in %0d texts under %0d pattern settings",
             items_sent, texts_sent, settings);
    $display("checked %0d output beats carrying %0d replacements, %0d mismatches",
             beats, replaced, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_stream_pattern_replace

`default_nettype wire
